FILE: src/tlt_pkg.sv
// Package: widths, limits and helpers shared by the toolpath length/time block.
`default_nettype none

package tlt_pkg;

  // Fixed field widths of the ports
  localparam int COORD_FIELD_BITS = 24;
  localparam int FEED_BITS        = 24;
  localparam int DIST_BITS        = 26;
  localparam int GLEN_BITS        = 40;
  localparam int TIME_BITS        = 48;

  // Internal arithmetic sizing
  localparam int COORD_BITS     = 24;
  localparam int LENGTH_BITS    = 40;
  localparam int TIME_FRAC_BITS = 16;

  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * ROOT_BITS;
  localparam int PROD_BITS = 2 * COORD_BITS;
  localparam int REM_BITS  = (ROOT_BITS + 1 > FEED_BITS) ? ROOT_BITS + 1 : FEED_BITS;
  localparam int STEP_BITS = (ROOT_BITS + 3 > FEED_BITS + 1) ? ROOT_BITS + 3 : FEED_BITS + 1;
  localparam int SUM_BITS  = ((LENGTH_BITS > ROOT_BITS) ? LENGTH_BITS : ROOT_BITS) + 1;
  localparam int DVD_BITS  = TIME_BITS + LENGTH_BITS;
  localparam int NITER_MAX = (ROOT_BITS > TIME_BITS) ? ROOT_BITS : TIME_BITS;
  localparam int CNT_BITS  = $clog2(NITER_MAX);

  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_BITS) - 64'd1;
  localparam logic [63:0] GLEN_MAX = (64'd1 << GLEN_BITS) - 64'd1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [TIME_BITS-1:0]   TIME_MAX = '1;

  // Take the low COORD_BITS of a coordinate field as a signed value
  function automatic logic signed [COORD_BITS-1:0] coord_of(
    input logic [COORD_FIELD_BITS-1:0] f
  );
    logic [63:0] w;
    w = 64'(f);
    return w[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/tlt_in_if.sv
// Interface: input point channel (valid/ready plus point payload).
`default_nettype none

interface tlt_in_if
  import tlt_pkg::*;
;
  logic                                valid;
  logic                                ready;
  logic signed [COORD_FIELD_BITS-1:0]  x_coord;
  logic signed [COORD_FIELD_BITS-1:0]  y_coord;
  logic signed [COORD_FIELD_BITS-1:0]  z_coord;
  logic                                sequence_start;
  logic                                group_end;

  modport source (
    output valid, x_coord, y_coord, z_coord, sequence_start, group_end,
    input  ready
  );
  modport sink (
    input  valid, x_coord, y_coord, z_coord, sequence_start, group_end,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/tlt_out_if.sv
// Interface: result channel (valid/ready plus distance, length and time payload).
`default_nettype none

interface tlt_out_if
  import tlt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [DIST_BITS-1:0]  segment_distance;
  logic [GLEN_BITS-1:0]  group_length;
  logic [TIME_BITS-1:0]  milling_time;
  logic                  time_valid;

  modport source (
    output valid, segment_distance, group_length, milling_time, time_valid,
    input  ready
  );
  modport sink (
    input  valid, segment_distance, group_length, milling_time, time_valid,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/tlt_cmp_sub.sv
// Shared compare-and-subtract unit used by the root and divide iterations.
`default_nettype none

module tlt_cmp_sub
  import tlt_pkg::*;
(
  input  wire logic [STEP_BITS-1:0] a,
  input  wire logic [STEP_BITS-1:0] b,
  output logic                      ge,
  output logic [STEP_BITS-1:0]      diff
);

  logic [STEP_BITS:0] wide;

  // Borrow out of the subtract decides the compare
  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[STEP_BITS];
  assign diff = wide[STEP_BITS-1:0];

endmodule

`default_nettype wire

FILE: src/toolpath_length_and_time_top.sv
// Top level: toolpath segment length, saturating group length and milling time.
// Sequence: square/sum, root, length update, quotient on a group end, output load; the quotient
//   is skipped off a group end, at zero speed or on saturation.
// A new point is taken only once the result is loaded into the output register; the shared
//   compare-subtract steps set the pace, and a stalled result holds the sequencer in its last state.
// Reset: synchronous rst_n clears previous point, group length, feed speed and output valid.
`default_nettype none

module toolpath_length_and_time_top
  import tlt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tlt_in_if.sink                    in_ch,
  tlt_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [FEED_BITS-1:0] cfg_wdata
);

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ   = 6'b000010,
    S_ROOT = 6'b000100,
    S_ACC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic [FEED_BITS-1:0]         speed_r, speed_nxt;

  logic signed [COORD_BITS-1:0] px_r, px_nxt;
  logic signed [COORD_BITS-1:0] py_r, py_nxt;
  logic signed [COORD_BITS-1:0] pz_r, pz_nxt;
  logic [COORD_BITS-1:0]        d_r   [3];
  logic [COORD_BITS-1:0]        d_nxt [3];
  logic                         gend_r, gend_nxt;

  logic [PROD_BITS-1:0]         prod_r, prod_nxt;
  logic [SQ_BITS-1:0]           sq_r, sq_nxt;
  logic [REM_BITS-1:0]          rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]         root_r, root_nxt;
  logic [LENGTH_BITS-1:0]       run_r, run_nxt;
  logic [TIME_BITS-1:0]         quo_r, quo_nxt;
  logic [DIST_BITS-1:0]         dist_h_r, dist_h_nxt;
  logic [GLEN_BITS-1:0]         glen_h_r, glen_h_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [DIST_BITS-1:0]         out_dist_r, out_dist_nxt;
  logic [GLEN_BITS-1:0]         out_glen_r, out_glen_nxt;
  logic [TIME_BITS-1:0]         out_time_r, out_time_nxt;
  logic                         out_tv_r, out_tv_nxt;

  // Shared unit hookup
  logic [STEP_BITS-1:0]         u_a, u_b, u_diff;
  logic                         u_ge;

  // Point intake helpers
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [COORD_BITS:0]   dfx, dfy, dfz;
  logic [COORD_BITS-1:0]        mx, my, mz;

  // Length update helpers
  logic [63:0]                  root64;
  logic [SUM_BITS-1:0]          len_sum;
  logic [LENGTH_BITS-1:0]       new_run;
  logic [63:0]                  run64;
  logic [DVD_BITS-1:0]          dvd;
  logic [LENGTH_BITS-1:0]       dvd_hi;
  logic [TIME_BITS-1:0]         dvd_lo;

  logic in_xfer;
  logic out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.segment_distance = out_dist_r;
  assign out_ch.group_length     = out_glen_r;
  assign out_ch.milling_time     = out_time_r;
  assign out_ch.time_valid       = out_tv_r;

  // Absolute coordinate deltas against the previous point
  always_comb begin
    cx  = coord_of(in_ch.x_coord);
    cy  = coord_of(in_ch.y_coord);
    cz  = coord_of(in_ch.z_coord);
    dfx = {cx[COORD_BITS-1], cx} - {px_r[COORD_BITS-1], px_r};
    dfy = {cy[COORD_BITS-1], cy} - {py_r[COORD_BITS-1], py_r};
    dfz = {cz[COORD_BITS-1], cz} - {pz_r[COORD_BITS-1], pz_r};
    mx  = dfx[COORD_BITS] ? COORD_BITS'(-dfx) : COORD_BITS'(dfx);
    my  = dfy[COORD_BITS] ? COORD_BITS'(-dfy) : COORD_BITS'(dfy);
    mz  = dfz[COORD_BITS] ? COORD_BITS'(-dfz) : COORD_BITS'(dfz);
  end

  // Saturating length update and dividend split
  always_comb begin
    root64  = 64'(root_r);
    len_sum = SUM_BITS'(run_r) + SUM_BITS'(root_r);
    new_run = (len_sum >= SUM_BITS'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(len_sum);
    run64   = 64'(new_run);
    dvd     = DVD_BITS'(new_run) << TIME_FRAC_BITS;
    dvd_hi  = dvd[DVD_BITS-1:TIME_BITS];
    dvd_lo  = dvd[TIME_BITS-1:0];
  end

  // Operand select for the shared unit: root trial or divisor trial
  always_comb begin
    unique case (state_r)
      S_ROOT: begin
        u_a = STEP_BITS'({rem_r[ROOT_BITS:0], sq_r[SQ_BITS-1 -: 2]});
        u_b = STEP_BITS'({root_r, 2'b01});
      end
      S_DIV: begin
        u_a = STEP_BITS'({rem_r[FEED_BITS-1:0], quo_r[TIME_BITS-1]});
        u_b = STEP_BITS'(speed_r);
      end
      default: begin
        u_a = '0;
        u_b = '0;
      end
    endcase
  end

  tlt_cmp_sub u_step (
    .a    (u_a),
    .b    (u_b),
    .ge   (u_ge),
    .diff (u_diff)
  );

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    speed_nxt     = cfg_we ? cfg_wdata : speed_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    d_nxt         = d_r;
    gend_nxt      = gend_r;
    prod_nxt      = prod_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    run_nxt       = run_r;
    quo_nxt       = quo_r;
    dist_h_nxt    = dist_h_r;
    glen_h_nxt    = glen_h_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_dist_nxt  = out_dist_r;
    out_glen_nxt  = out_glen_r;
    out_time_nxt  = out_time_r;
    out_tv_nxt    = out_tv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // A polyline start measures nothing: zero deltas
          d_nxt[0]  = in_ch.sequence_start ? '0 : mx[COORD_BITS-1:0];
          d_nxt[1]  = in_ch.sequence_start ? '0 : my[COORD_BITS-1:0];
          d_nxt[2]  = in_ch.sequence_start ? '0 : mz[COORD_BITS-1:0];
          px_nxt    = cx;
          py_nxt    = cy;
          pz_nxt    = cz;
          gend_nxt  = in_ch.group_end;
          sq_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // Square one delta a cycle, sum the previous product
        prod_nxt = d_r[0] * d_r[0];
        d_nxt[0] = d_r[1];
        d_nxt[1] = d_r[2];
        if (cnt_r != '0) begin
          sq_nxt = sq_r + SQ_BITS'(prod_r);
        end
        if (cnt_r == CNT_BITS'(3)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_BITS'(ROOT_BITS - 1);
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
      end
      S_ROOT: begin
        // One root bit per cycle, two radicand bits consumed
        rem_nxt  = u_ge ? REM_BITS'(u_diff) : REM_BITS'(u_a);
        root_nxt = {root_r[ROOT_BITS-2:0], u_ge};
        sq_nxt   = sq_r << 2;
        if (cnt_r == '0) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
        end
      end
      S_ACC: begin
        dist_h_nxt = (root64 > DIST_MAX) ? DIST_BITS'(DIST_MAX) : DIST_BITS'(root64);
        glen_h_nxt = (run64 > GLEN_MAX) ? GLEN_BITS'(GLEN_MAX) : GLEN_BITS'(run64);
        state_nxt  = S_DONE;
        if (gend_r) begin
          run_nxt = '0;
          priority if (speed_r == '0) begin
            quo_nxt = '0;
          end else if (dvd_hi >= LENGTH_BITS'(speed_r)) begin
            // Quotient would need more than the time field holds: saturate
            quo_nxt = TIME_MAX;
          end else begin
            rem_nxt   = REM_BITS'(dvd_hi);
            quo_nxt   = dvd_lo;
            cnt_nxt   = CNT_BITS'(TIME_BITS - 1);
            state_nxt = S_DIV;
          end
        end else begin
          run_nxt = new_run;
          quo_nxt = '0;
        end
      end
      S_DIV: begin
        // Restoring division: shift dividend out, quotient bits in
        rem_nxt = u_ge ? REM_BITS'(u_diff) : REM_BITS'(u_a);
        quo_nxt = {quo_r[TIME_BITS-2:0], u_ge};
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
        end
      end
      S_DONE: begin
        // Hold until the output register is free, then load it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_h_r;
          out_glen_nxt  = glen_h_r;
          out_time_nxt  = quo_r;
          out_tv_nxt    = gend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and architectural state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      speed_r     <= '0;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      run_r       <= '0;
      gend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      speed_r     <= speed_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pz_r        <= pz_nxt;
      run_r       <= run_nxt;
      gend_r      <= gend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    prod_r     <= prod_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    quo_r      <= quo_nxt;
    dist_h_r   <= dist_h_nxt;
    glen_h_r   <= glen_h_nxt;
    out_dist_r <= out_dist_nxt;
    out_glen_r <= out_glen_nxt;
    out_time_r <= out_time_nxt;
    out_tv_r   <= out_tv_nxt;
  end

`ifndef ASSERT_OFF
  // A transfer starts the sequencer, so the input closes next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input still ready after a transfer");

  // Root remainder never exceeds twice the partial root
  a_root_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> ({1'b0, rem_r} <= (REM_BITS + 1)'({root_r, 1'b0})))
    else $error("root remainder out of bound");

  // Milling time only carries a value on a group end
  a_time_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tv_r) |-> (out_time_r == '0))
    else $error("milling time nonzero without group end");
`endif

endmodule

`default_nettype wire
